// ===== sv/detection_candidate_decoder_top_assert.svh =====
// Assertion macros used by the detection candidate decoder checker.
`ifndef DETECTION_CANDIDATE_DECODER_TOP_ASSERT_SVH
`define DETECTION_CANDIDATE_DECODER_TOP_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define DDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define DDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/ddc_pkg.sv =====
// Shared types and constants of the detection candidate decoder.
package ddc_pkg;

    // Candidate layout
    localparam int MAX_CLASSES = 1024;
    localparam int BOX_ATTRS   = 4;
    localparam int JOB_DEPTH   = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_INVERSE_SCALE   = 3'd1;
    localparam logic [2:0] CFG_PAD_LEFT        = 3'd2;
    localparam logic [2:0] CFG_PAD_TOP         = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd5;

    // Largest image side used for clamping
    localparam logic [13:0] MAX_IMAGE_SIDE = 14'd8192;

    // One accepted candidate handed from front to back
    typedef struct packed {
        logic        [9:0]  class_id;
        logic signed [31:0] score;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] bw;
        logic signed [31:0] bh;
    } t_job;

    // Letterbox settings used by the box datapath
    typedef struct packed {
        logic [23:0] inverse_scale;
        logic [12:0] pad_left;
        logic [12:0] pad_top;
        logic [13:0] image_width;
        logic [13:0] image_height;
    } t_box_cfg;

endpackage

// ===== sv/ddc_front.sv =====
// Front end: attribute intake, box capture, running argmax and threshold check.
module ddc_front import ddc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic signed [31:0] i_attr_value,
    input  logic               i_last_attr,
    input  logic               i_queue_full,
    input  logic [16:0]        i_score_threshold,
    output logic               o_in_stall,
    output logic               o_push,
    output t_job               o_push_job
);

    localparam logic [10:0] CLS_END   = 11'(MAX_CLASSES + BOX_ATTRS);
    localparam logic [10:0] IDX_MAX   = 11'h7FF;
    localparam logic [10:0] BOX_COUNT = 11'(BOX_ATTRS);

    logic [10:0]        r_attr_index;
    logic signed [31:0] r_best_score;
    logic [9:0]         r_best_class;
    logic signed [31:0] r_box [BOX_ATTRS];

    logic               accept;
    logic               is_box;
    logic               better;
    logic signed [31:0] n_best_score;
    logic [9:0]         n_best_class;
    logic [10:0]        n_attr_index;
    logic [10:0]        cls_index;

    // Hold the source while the queue has no room
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // Classify the beat and update the argmax; the first class wins ties
    always_comb begin
        is_box       = r_attr_index < BOX_COUNT;
        cls_index    = r_attr_index - BOX_COUNT;
        better       = !is_box && (r_attr_index < CLS_END) && (i_attr_value > r_best_score);
        n_best_score = better ? i_attr_value : r_best_score;
        n_best_class = better ? cls_index[9:0] : r_best_class;
        n_attr_index = (r_attr_index == IDX_MAX) ? r_attr_index : r_attr_index + 11'd1;
    end

    // Emit a job when a full candidate reaches the threshold
    assign o_push = accept && i_last_attr && !is_box &&
                    (n_best_score >= $signed({15'd0, i_score_threshold}));

    always_comb begin
        o_push_job.class_id = n_best_class;
        o_push_job.score    = n_best_score;
        o_push_job.cx       = r_box[0];
        o_push_job.cy       = r_box[1];
        o_push_job.bw       = r_box[2];
        o_push_job.bh       = r_box[3];
    end

    // Advance the candidate state; restart after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_index <= '0;
            r_best_score <= 32'sh8000_0000;
            r_best_class <= '0;
        end else if (accept) begin
            if (i_last_attr) begin
                r_attr_index <= '0;
                r_best_score <= 32'sh8000_0000;
                r_best_class <= '0;
            end else begin
                r_attr_index <= n_attr_index;
                r_best_score <= n_best_score;
                r_best_class <= n_best_class;
            end
        end
    end

    // Capture the box attributes
    always_ff @(posedge i_clk) begin
        if (accept && is_box) begin
            r_box[r_attr_index[1:0]] <= i_attr_value;
        end
    end

endmodule

// ===== sv/ddc_fifo.sv =====
// Short job queue between front and back with a registered head.
module ddc_fifo import ddc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    input  logic i_advance,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head_job
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_head_valid;
    t_job             r_head_job;
    logic             pop;

    assign o_full       = r_count == CNT_W'(JOB_DEPTH);
    assign pop          = i_advance && (r_count != '0);
    assign o_head_valid = r_head_valid;
    assign o_head_job   = r_head_job;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_head_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
            if (i_advance) begin
                r_head_valid <= pop;
            end
        end
    end

    // Write the storage and register the read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
        if (pop) begin
            r_head_job <= r_mem[r_rd_ptr];
        end
    end

endmodule

// ===== sv/ddc_back.sv =====
// Back end: letterbox inverse, floor and ceiling, clamping and output register.
module ddc_back import ddc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    input  t_box_cfg    i_cfg,
    input  logic        i_out_stall,
    output logic        o_advance,
    output logic        o_out_valid,
    output logic [9:0]  o_class_id,
    output logic [31:0] o_score,
    output logic [12:0] o_box_left,
    output logic [12:0] o_box_top,
    output logic [13:0] o_box_right,
    output logic [13:0] o_box_bottom
);

    // Lanes: 0 left, 1 top, 2 right, 3 bottom
    logic               r_s1_valid;
    logic [9:0]         r_s1_class;
    logic [31:0]        r_s1_score;
    logic signed [34:0] r_s1_sum [4];

    logic               r_s2_valid;
    logic [9:0]         r_s2_class;
    logic [31:0]        r_s2_score;
    logic signed [47:0] r_s2_lo [4];
    logic signed [47:0] r_s2_hi [4];

    logic               r_s3_valid;
    logic [9:0]         r_s3_class;
    logic [31:0]        r_s3_score;
    logic signed [26:0] r_s3_edge [4];

    logic               r_out_valid;
    logic [9:0]         r_out_class;
    logic [31:0]        r_out_score;
    logic [13:0]        r_out_edge [4];

    logic signed [34:0] n_sum [4];
    logic signed [47:0] n_lo [4];
    logic signed [47:0] n_hi [4];
    logic signed [26:0] n_edge [4];
    logic [13:0]        n_clamped [4];
    logic signed [34:0] cx2;
    logic signed [34:0] cy2;
    logic signed [34:0] bw_x;
    logic signed [34:0] bh_x;
    logic signed [34:0] px_x;
    logic signed [34:0] py_x;
    logic signed [12:0] k_lo;
    logic signed [12:0] k_hi;
    logic signed [59:0] full_prod;
    logic [13:0]        w_lim;
    logic [13:0]        h_lim;
    logic signed [14:0] edge_hi [4];
    logic               non_empty;

    // Clamp a signed edge into [0, hi]
    function automatic logic [13:0] clamp_edge(input logic signed [26:0] e,
                                               input logic signed [14:0] hi);
        logic signed [26:0] v;
        v = e;
        if (v > $signed({{12{hi[14]}}, hi})) begin
            v = $signed({{12{hi[14]}}, hi});
        end
        if (v < 27'sd0) begin
            v = 27'sd0;
        end
        return v[13:0];
    endfunction

    // Move the whole pipeline unless the result register is held
    assign o_advance = !(r_out_valid && i_out_stall);

    // Stage 1: doubled center minus or plus size, minus doubled padding
    always_comb begin
        cx2  = {{2{i_job.cx[31]}}, i_job.cx, 1'b0};
        cy2  = {{2{i_job.cy[31]}}, i_job.cy, 1'b0};
        bw_x = {{3{i_job.bw[31]}}, i_job.bw};
        bh_x = {{3{i_job.bh[31]}}, i_job.bh};
        px_x = {5'd0, i_cfg.pad_left, 17'd0};
        py_x = {5'd0, i_cfg.pad_top, 17'd0};
        n_sum[0] = cx2 - bw_x - px_x;
        n_sum[1] = cy2 - bh_x - py_x;
        n_sum[2] = cx2 + bw_x - px_x;
        n_sum[3] = cy2 + bh_x - py_x;
    end

    // Stage 2: partial products against the two halves of the scale
    always_comb begin
        k_lo = {1'b0, i_cfg.inverse_scale[11:0]};
        k_hi = {1'b0, i_cfg.inverse_scale[23:12]};
        for (int i = 0; i < 4; i++) begin
            n_lo[i] = r_s1_sum[i] * k_lo;
            n_hi[i] = r_s1_sum[i] * k_hi;
        end
    end

    // Stage 3: combine partials; floor for left and top, ceiling for right and bottom
    always_comb begin
        full_prod = '0;
        for (int i = 0; i < 4; i++) begin
            full_prod = $signed({r_s2_hi[i], 12'd0}) +
                        $signed({{12{r_s2_lo[i][47]}}, r_s2_lo[i]});
            if (i >= 2) begin
                full_prod = full_prod + 60'sh1_FFFF_FFFF;
            end
            n_edge[i] = full_prod[59:33];
        end
    end

    // Stage 4: clamp to the image and drop empty boxes
    always_comb begin
        w_lim = (i_cfg.image_width > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : i_cfg.image_width;
        h_lim = (i_cfg.image_height > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : i_cfg.image_height;
        edge_hi[0] = $signed({1'b0, w_lim}) - 15'sd1;
        edge_hi[1] = $signed({1'b0, h_lim}) - 15'sd1;
        edge_hi[2] = $signed({1'b0, w_lim});
        edge_hi[3] = $signed({1'b0, h_lim});
        for (int i = 0; i < 4; i++) begin
            n_clamped[i] = clamp_edge(r_s3_edge[i], edge_hi[i]);
        end
        non_empty = (n_clamped[2] > n_clamped[0]) && (n_clamped[3] > n_clamped[1]);
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_s1_valid  <= i_job_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid && non_empty;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_s1_class  <= i_job.class_id;
            r_s1_score  <= i_job.score;
            r_s2_class  <= r_s1_class;
            r_s2_score  <= r_s1_score;
            r_s3_class  <= r_s2_class;
            r_s3_score  <= r_s2_score;
            r_out_class <= r_s3_class;
            r_out_score <= r_s3_score;
            for (int i = 0; i < 4; i++) begin
                r_s1_sum[i]   <= n_sum[i];
                r_s2_lo[i]    <= n_lo[i];
                r_s2_hi[i]    <= n_hi[i];
                r_s3_edge[i]  <= n_edge[i];
                r_out_edge[i] <= n_clamped[i];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_class_id   = r_out_class;
    assign o_score      = r_out_score;
    assign o_box_left   = r_out_edge[0][12:0];
    assign o_box_top    = r_out_edge[1][12:0];
    assign o_box_right  = r_out_edge[2];
    assign o_box_bottom = r_out_edge[3];

endmodule

// ===== sv/detection_candidate_decoder_top.sv =====
// A finished candidate passes the job queue, its registered head and the box pipeline.
// Throughput: one attribute beat per cycle; the output register, the four-stage box
// pipeline and the four-entry job queue let intake go on while a result is held.
// Intake stalls only when the job queue is full.
// Reset (synchronous, active low) loads the register defaults and empties the queue.
module detection_candidate_decoder_top import ddc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_attr_value,
    input  logic        i_last_attr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_class_id,
    output logic [31:0] o_score,
    output logic [12:0] o_box_left,
    output logic [12:0] o_box_top,
    output logic [13:0] o_box_right,
    output logic [13:0] o_box_bottom,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [16:0] r_score_threshold;
    t_box_cfg    r_box_cfg;

    logic        queue_full;
    logic        push;
    t_job        push_job;
    logic        advance;
    logic        head_valid;
    t_job        head_job;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_threshold       <= 17'd16384;
            r_box_cfg.inverse_scale <= 24'd65536;
            r_box_cfg.pad_left      <= 13'd0;
            r_box_cfg.pad_top       <= 13'd0;
            r_box_cfg.image_width   <= 14'd640;
            r_box_cfg.image_height  <= 14'd640;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCORE_THRESHOLD: r_score_threshold       <= i_cfg_data[16:0];
                CFG_INVERSE_SCALE:   r_box_cfg.inverse_scale <= i_cfg_data;
                CFG_PAD_LEFT:        r_box_cfg.pad_left      <= i_cfg_data[12:0];
                CFG_PAD_TOP:         r_box_cfg.pad_top       <= i_cfg_data[12:0];
                CFG_IMAGE_WIDTH:     r_box_cfg.image_width   <= i_cfg_data[13:0];
                CFG_IMAGE_HEIGHT:    r_box_cfg.image_height  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    ddc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_attr_value      ($signed(i_attr_value)),
        .i_last_attr       (i_last_attr),
        .i_queue_full      (queue_full),
        .i_score_threshold (r_score_threshold),
        .o_in_stall        (o_in_stall),
        .o_push            (push),
        .o_push_job        (push_job)
    );

    ddc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .i_advance    (advance),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head_job   (head_job)
    );

    ddc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (head_valid),
        .i_job        (head_job),
        .i_cfg        (r_box_cfg),
        .i_out_stall  (i_out_stall),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .o_class_id   (o_class_id),
        .o_score      (o_score),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_right  (o_box_right),
        .o_box_bottom (o_box_bottom)
    );

endmodule

// ===== sv/ddc_checker.sv =====
// Port-level checker for the detection candidate decoder and its bind.
`include "detection_candidate_decoder_top_assert.svh"

module ddc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [12:0] o_box_left,
    input logic [12:0] o_box_top,
    input logic [13:0] o_box_right,
    input logic [13:0] o_box_bottom
);

    // A held result keeps its left and right edges
    `DDC_ASSERT(a_hold_box, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_box_left) && $stable(o_box_right), "held result changed")

    // Every delivered box is non-empty
    `DDC_ASSERT(a_non_empty, o_out_valid |-> (o_box_right > o_box_left) && (o_box_bottom > o_box_top), "empty box delivered")

    // Edges stay inside the largest image
    `DDC_ASSERT(a_edge_range, o_out_valid |-> (o_box_right <= 14'd8192) && (o_box_bottom <= 14'd8192), "edge beyond image range")

    // Reset leaves no result pending and intake open
    `DDC_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid && !o_in_stall, "state not cleared by reset")

endmodule

bind detection_candidate_decoder_top ddc_checker u_ddc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the detection candidate decoder: predicts boxes, compares detections.
module testbench;
    import ddc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_LEN     = 400;
    localparam int QUIET_FROM   = 200;
    localparam int QUIET_TO     = 500;
    localparam int IDLE_PCT     = 33;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_attr_beat;

    typedef struct packed {
        logic [9:0]  class_id;
        logic [31:0] score;
        logic [12:0] left;
        logic [12:0] top;
        logic [13:0] right;
        logic [13:0] bottom;
    } t_detection;

    // DUT ports
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_attr_value = '0;
    logic        i_last_attr  = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [9:0]  o_class_id;
    logic [31:0] o_score;
    logic [12:0] o_box_left;
    logic [12:0] o_box_top;
    logic [13:0] o_box_right;
    logic [13:0] o_box_bottom;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index  = '0;
    logic [23:0] i_cfg_data   = '0;

    // Stimulus and expectation stores
    t_attr_beat attr_beats[$];
    t_detection expected_dets[$];

    // Register mirror, starting at the reset defaults
    logic [16:0] thr_q = 17'd16384;
    logic [23:0] inv_q = 24'd65536;
    logic [12:0] pad_x = '0;
    logic [12:0] pad_y = '0;
    logic [13:0] img_w = 14'd640;
    logic [13:0] img_h = 14'd640;

    // Candidate accumulation state
    int unsigned        cand_len   = 0;
    logic signed [31:0] lead_score = 32'sh8000_0000;
    int unsigned        lead_class = 0;
    logic signed [31:0] box_attr [BOX_ATTRS];

    // Bookkeeping
    int  mismatches     = 0;
    int  beats_in       = 0;
    int  dets_checked   = 0;
    int  cands_dropped  = 0;
    int  in_stall_cycles = 0;
    int  phases_run     = 1;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    logic hold_done     = 1'b0;
    logic rest_on;

    detection_candidate_decoder_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_attr_value (i_attr_value),
        .i_last_attr  (i_last_attr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_class_id   (o_class_id),
        .o_score      (o_score),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_right  (o_box_right),
        .o_box_bottom (o_box_bottom),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Random idling everywhere except one quiet stretch of beats
    assign rest_on = !(beats_in >= QUIET_FROM && beats_in < QUIET_TO);

    function automatic longint clamp_edge(longint v, longint hi);
        if (v > hi) v = hi;
        if (v < 0) v = 0;
        return v;
    endfunction

    // Absorb one attribute beat; at a candidate end, queue the detection it should give
    function automatic void decode_attr(logic [31:0] val, logic fin);
        int unsigned        seen;
        logic signed [31:0] sc;
        int unsigned        cl;
        longint             cx2, cy2, bw, bh, px, py, k, w, h, thr;
        longint             l, t, r, b;
        t_detection         det;
        if (cand_len < BOX_ATTRS) begin
            box_attr[cand_len] = val;
        end else if (cand_len - BOX_ATTRS < MAX_CLASSES && $signed(val) > lead_score) begin
            lead_score = val;
            lead_class = cand_len - BOX_ATTRS;
        end
        seen = cand_len + 1;
        if (cand_len < 2047) cand_len++;
        if (!fin) return;

        sc = lead_score;
        cl = lead_class;
        cand_len   = 0;
        lead_score = 32'sh8000_0000;
        lead_class = 0;

        thr = longint'(thr_q);
        if (seen < BOX_ATTRS + 1 || longint'(sc) < thr) begin
            cands_dropped++;
            return;
        end

        // Undo the letterbox in units of 2^-33, then floor or ceil to pixels
        cx2 = 2 * longint'(box_attr[0]);
        cy2 = 2 * longint'(box_attr[1]);
        bw  = longint'(box_attr[2]);
        bh  = longint'(box_attr[3]);
        px  = longint'(pad_x);
        py  = longint'(pad_y);
        px  = px * 131072;
        py  = py * 131072;
        k   = longint'(inv_q);
        w   = longint'(img_w);
        h   = longint'(img_h);
        if (w > 8192) w = 8192;
        if (h > 8192) h = 8192;
        l = ((cx2 - bw - px) * k) >>> 33;
        t = ((cy2 - bh - py) * k) >>> 33;
        r = -((-((cx2 + bw - px) * k)) >>> 33);
        b = -((-((cy2 + bh - py) * k)) >>> 33);
        l = clamp_edge(l, w - 1);
        t = clamp_edge(t, h - 1);
        r = clamp_edge(r, w);
        b = clamp_edge(b, h);
        if (r <= l || b <= t) begin
            cands_dropped++;
            return;
        end

        det.class_id = cl[9:0];
        det.score    = sc;
        det.left     = l[12:0];
        det.top      = t[12:0];
        det.right    = r[13:0];
        det.bottom   = b[13:0];
        expected_dets.insert(expected_dets.size(), det);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic check_detection();
        t_detection want;
        if (expected_dets.size() == 0) begin
            report_mismatch($sformatf("detection with none expected, class %0d", o_class_id));
            return;
        end
        want = expected_dets.pop_front();
        check_field("class_id",   32'(o_class_id),   32'(want.class_id));
        check_field("score",      o_score,           want.score);
        check_field("box_left",   32'(o_box_left),   32'(want.left));
        check_field("box_top",    32'(o_box_top),    32'(want.top));
        check_field("box_right",  32'(o_box_right),  32'(want.right));
        check_field("box_bottom", 32'(o_box_bottom), 32'(want.bottom));
        dets_checked++;
    endtask

    // Driver: predict on each accepted beat, then load the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_attr(i_attr_value, i_last_attr);
                beats_in <= beats_in + 1;
            end
            if (i_in_valid && o_in_stall)
                in_stall_cycles <= in_stall_cycles + 1;
            if (!i_in_valid || !o_in_stall) begin
                if (attr_beats.size() != 0 &&
                    !(rest_on && $urandom_range(0, 99) < IDLE_PCT)) begin
                    i_attr_value <= attr_beats[0].value;
                    i_last_attr  <= attr_beats[0].last;
                    void'(attr_beats.pop_front());
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed once the stream is flowing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each accepted detection, stall at random and during the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_detection();
            i_out_stall <= (hold_left != 0) || (rest_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    task automatic push_beat(logic [31:0] v, logic fin);
        attr_beats.insert(attr_beats.size(), t_attr_beat'{value: v, last: fin});
    endtask

    task automatic push_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] bw, logic [31:0] bh);
        push_beat(cx, 1'b0);
        push_beat(cy, 1'b0);
        push_beat(bw, 1'b0);
        push_beat(bh, 1'b0);
    endtask

    function automatic logic [31:0] rand_center(int pad);
        int off;
        if ($urandom_range(0, 9) == 0) return $urandom;
        off = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 1000);
        return ((pad + off) << 16) | $urandom_range(0, 65535);
    endfunction

    function automatic logic [31:0] rand_extent();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return ($urandom_range(0, 300) << 16) | $urandom_range(0, 65535);
    endfunction

    // Mostly well-formed candidates, plus short ones and raw noise
    task automatic push_random(int budget);
        int          pushed;
        int          n;
        int          kind;
        logic [31:0] s;
        logic [31:0] prev;
        pushed = 0;
        while (pushed < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) push_beat($urandom, i == n - 1);
            end else if (kind < 15) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    push_beat($urandom, i == n - 1 || $urandom_range(0, 5) == 0);
            end else begin
                push_box(rand_center(int'(pad_x)), rand_center(int'(pad_y)),
                         rand_extent(), rand_extent());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
                prev = 32'(thr_q);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 9))
                        0: s = $urandom;
                        1: s = prev;
                        default: s = int'(thr_q) + $urandom_range(0, 65536) - 32768;
                    endcase
                    prev = s;
                    push_beat(s, i == n - 1);
                end
                n += BOX_ATTRS;
            end
            pushed += n;
        end
    endtask

    // Wait for all beats accepted and all detections back, then let the pipe empty
    task automatic settle();
        while (attr_beats.size() != 0 || i_in_valid || expected_dets.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCORE_THRESHOLD: thr_q = val[16:0];
            CFG_INVERSE_SCALE:   inv_q = val;
            CFG_PAD_LEFT:        pad_x = val[12:0];
            CFG_PAD_TOP:         pad_y = val[12:0];
            CFG_IMAGE_WIDTH:     img_w = val[13:0];
            CFG_IMAGE_HEIGHT:    img_h = val[13:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int thr, int inv, int pl, int pt, int w, int h);
        write_reg(CFG_SCORE_THRESHOLD, 24'(thr));
        write_reg(CFG_INVERSE_SCALE,   24'(inv));
        write_reg(CFG_PAD_LEFT,        24'(pl));
        write_reg(CFG_PAD_TOP,         24'(pt));
        write_reg(CFG_IMAGE_WIDTH,     24'(w));
        write_reg(CFG_IMAGE_HEIGHT,    24'(h));
        i_cfg_valid <= 1'b0;
        phases_run++;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases under the reset settings
        push_beat(32'h7FFF_FFFF, 1'b1);                       // lone last beat
        push_beat(32'h8000_0000, 1'b0);                       // short candidate, no class
        push_beat(32'h0001_0000, 1'b1);
        push_box(32'd320 << 16, 32'd320 << 16, 32'd100 << 16, 32'd50 << 16);
        push_beat(32'd16384, 1'b1);                           // exactly at threshold
        push_box(32'd320 << 16, 32'd320 << 16, 32'd100 << 16, 32'd50 << 16);
        push_beat(32'd16383, 1'b1);                           // one below threshold
        push_box(32'h000A_8000, 32'h0014_4000, 32'd30 << 16, 32'd40 << 16);
        push_beat(32'h8000_0000, 1'b0);                       // tie: earlier class wins
        push_beat(32'h0001_8000, 1'b0);
        push_beat(32'h0001_8000, 1'b1);
        push_box(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_beat(32'h7FFF_FFFF, 1'b1);                       // edges clamp both ways
        push_box(32'd320 << 16, 32'd320 << 16, -(32'd10 << 16), 32'd10 << 16);
        push_beat(32'h0001_0000, 1'b1);                       // negative width, empty box

        push_random(300);
        settle();

        // Setting sweep: extremes, typical, degenerate, width above the cap, then random
        apply_setting(0, 1, 0, 0, 1, 1);
        push_random(60);
        settle();
        apply_setting(65536, 16777215, 8191, 8191, 8192, 8192);
        push_random(60);
        settle();
        apply_setting(32768, 40960, 80, 0, 1920, 1080);
        push_random(60);
        settle();
        apply_setting(16384, 0, 0, 0, 640, 640);               // zero scale drops all
        push_random(30);
        settle();
        apply_setting(0, 65536, 0, 0, 0, 16383);               // zero width drops all
        push_random(30);
        settle();
        apply_setting(4096, 98304, 10, 20, 16383, 480);        // width above the cap
        push_random(60);
        settle();
        apply_setting($urandom_range(0, 65536), $urandom_range(16384, 262144),
                      $urandom_range(0, 8191), $urandom_range(0, 200),
                      $urandom_range(1, 8192), $urandom_range(1, 8192));
        push_random(60);
        settle();

        $display("summary: %0d attribute beats over %0d setting phases, %0d detections checked",
                 beats_in, phases_run, dets_checked);
        $display("summary: %0d candidates dropped, %0d cycles with intake held off, %0d mismatches",
                 cands_dropped, in_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
